// ===== rtl/qpi_pkg.sv =====
// ============================================================================
// qpi_pkg: shared types and constants for the quadtree point insert block
// Request payload types, the walk state type, register indexes and widths.
// ============================================================================
package qpi_pkg;

    // Fixed field widths of the request and result payloads.
    localparam int COORD_BITS    = 16;
    localparam int NODE_BITS     = 12;
    localparam int LEVEL_BITS    = 5;
    localparam int DEPTH_BITS    = 5;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    // Defaults for the top level parameters.
    localparam int NODE_SLOTS_DEF = 4096;
    localparam int MAX_LEVELS_DEF = 16;

    // Slot of the root node; slots 0..3 form the root group.
    localparam int ROOT_SLOT  = 3;
    localparam int FIRST_FREE = 4;
    localparam int GROUP_SIZE = 4;

    // Quadrant code bits.
    localparam int QUAD_EAST  = 0;
    localparam int QUAD_SOUTH = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_DEPTH   = 2'd2;

    // Register reset values.
    localparam logic [COORD_BITS-1:0] GRID_WIDTH_RST  = 16'd256;
    localparam logic [COORD_BITS-1:0] GRID_HEIGHT_RST = 16'd256;
    localparam logic [DEPTH_BITS-1:0] MAX_DEPTH_RST   = 5'd16;

    typedef struct packed {
        logic [COORD_BITS-1:0] point_x;
        logic [COORD_BITS-1:0] point_y;
    } t_point;

    typedef struct packed {
        logic [NODE_BITS-1:0]  node_index;
        logic [LEVEL_BITS-1:0] level;
        logic                  rejected;
        logic                  store_full;
        logic                  last;
    } t_result;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK
    } t_state;

endpackage

// ===== rtl/qpi_stream_if.sv =====
// ============================================================================
// qpi_stream_if: valid/ready request channel
// Carries one payload of a selectable type from a source to a sink.
// ============================================================================
interface qpi_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/qpi_ram.sv =====
// ============================================================================
// qpi_ram: simple dual-port synchronous RAM
// One write port and one read port with registered read data.
// ============================================================================
module qpi_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/quadtree_point_insert.sv =====
// ============================================================================
// quadtree_point_insert: region quadtree point insertion
// Walks a quadtree held in a child-link RAM and reports every visited node.
// ============================================================================
// Walk: an accepted request loads the walk registers and reads the root
// link word; each level in ST_WALK then registers one result, and the last
// result returns the block to ST_IDLE, the only state that takes requests.
// Each level does a single read-modify-write of the child-link RAM. A
// stalled output holds the walk. Reset: after i_rst_n the RAM is cleared
// one slot per cycle, all NODE_SLOTS slots (4096 by default), before the
// first request is taken.
// ============================================================================
module quadtree_point_insert #(
    parameter int NODE_SLOTS = qpi_pkg::NODE_SLOTS_DEF,
    parameter int MAX_LEVELS = qpi_pkg::MAX_LEVELS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [qpi_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [qpi_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    qpi_stream_if.sink                        i_pt,
    qpi_stream_if.source                      o_res
);
    localparam int SLOT_BITS = $clog2(NODE_SLOTS);
    localparam int LVL_BITS  = $clog2(MAX_LEVELS + 1);
    localparam int CMP_W     = (LVL_BITS > qpi_pkg::DEPTH_BITS) ? LVL_BITS
                                                                : qpi_pkg::DEPTH_BITS;
    localparam int CB        = qpi_pkg::COORD_BITS;

    // ------------------------------------------------------------------
    // Config registers. Writes must come only while the block is idle; unchecked.
    // ------------------------------------------------------------------
    logic [CB-1:0]                  r_grid_width;
    logic [CB-1:0]                  r_grid_height;
    logic [qpi_pkg::DEPTH_BITS-1:0] r_max_depth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= qpi_pkg::GRID_WIDTH_RST;
            r_grid_height <= qpi_pkg::GRID_HEIGHT_RST;
            r_max_depth   <= qpi_pkg::MAX_DEPTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                qpi_pkg::CFG_GRID_WIDTH:  r_grid_width  <= i_cfg_data;
                qpi_pkg::CFG_GRID_HEIGHT: r_grid_height <= i_cfg_data;
                qpi_pkg::CFG_MAX_DEPTH:   r_max_depth   <= i_cfg_data[qpi_pkg::DEPTH_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Child-link RAM. An entry of zero marks a leaf; otherwise it holds the
    // first slot of the node's group of four children.
    // ------------------------------------------------------------------
    logic                 ram_we;
    logic [SLOT_BITS-1:0] ram_waddr;
    logic [SLOT_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [SLOT_BITS-1:0] ram_raddr;
    logic [SLOT_BITS-1:0] ram_rdata;

    qpi_ram #(
        .WIDTH (SLOT_BITS),
        .DEPTH (NODE_SLOTS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Walk state. r_node is the node whose link word sits on ram_rdata while
    // in ST_WALK; r_left/r_top/r_w/r_h describe that node's cell.
    // ------------------------------------------------------------------
    qpi_pkg::t_state       r_state, n_state;
    logic [SLOT_BITS-1:0]  r_clr_addr, n_clr_addr;
    logic [SLOT_BITS:0]    r_next_free, n_next_free;
    logic [CB-1:0]         r_px, n_px;
    logic [CB-1:0]         r_py, n_py;
    logic [CB-1:0]         r_left, n_left;
    logic [CB-1:0]         r_top, n_top;
    logic [CB-1:0]         r_w, n_w;
    logic [CB-1:0]         r_h, n_h;
    logic [SLOT_BITS-1:0]  r_node, n_node;
    logic [LVL_BITS-1:0]   r_lvl, n_lvl;
    logic                  r_reject, n_reject;
    logic                  r_out_valid, n_out_valid;
    qpi_pkg::t_result      r_out, n_out;

    // Helper values for the current level.
    logic [CB-1:0]         cx, cy;
    logic [1:0]            quad;
    logic [CMP_W-1:0]      limit;
    logic                  stop_geo;
    logic                  is_leaf;
    logic                  full;
    logic                  out_free;
    logic [SLOT_BITS-1:0]  first;
    logic [SLOT_BITS-1:0]  child;

    always_comb begin
        cx = r_left + (r_w >> 1);
        cy = r_top + (r_h >> 1);
        quad[qpi_pkg::QUAD_EAST]  = (r_px >= cx);
        quad[qpi_pkg::QUAD_SOUTH] = (r_py >= cy);

        // Depth limit is the configured depth clamped to the built levels.
        if (CMP_W'(r_max_depth) > CMP_W'(MAX_LEVELS)) begin
            limit = CMP_W'(MAX_LEVELS);
        end else begin
            limit = CMP_W'(r_max_depth);
        end

        // The walk ends at the depth limit or once the cell is a single unit.
        stop_geo = (CMP_W'(r_lvl) >= limit) || !((r_w > CB'(1)) || (r_h > CB'(1)));
        is_leaf  = (ram_rdata == '0);
        full     = (r_next_free > (SLOT_BITS + 1)'(NODE_SLOTS - qpi_pkg::GROUP_SIZE));
        first    = is_leaf ? r_next_free[SLOT_BITS-1:0] : ram_rdata;
        child    = first + SLOT_BITS'(quad);
        out_free = !r_out_valid || o_res.ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qpi_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_next_free <= (SLOT_BITS + 1)'(qpi_pkg::FIRST_FREE);
            r_out_valid <= 1'b0;
        end else begin
            r_clr_addr  <= n_clr_addr;
            r_next_free <= n_next_free;
            r_out_valid <= n_out_valid;
        end
        r_px     <= n_px;
        r_py     <= n_py;
        r_left   <= n_left;
        r_top    <= n_top;
        r_w      <= n_w;
        r_h      <= n_h;
        r_node   <= n_node;
        r_lvl    <= n_lvl;
        r_reject <= n_reject;
        r_out    <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_next_free = r_next_free;
        n_px        = r_px;
        n_py        = r_py;
        n_left      = r_left;
        n_top       = r_top;
        n_w         = r_w;
        n_h         = r_h;
        n_node      = r_node;
        n_lvl       = r_lvl;
        n_reject    = r_reject;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_res.ready;

        ram_we      = 1'b0;
        ram_waddr   = r_node;
        ram_wdata   = first;
        ram_re      = 1'b0;
        ram_raddr   = child;
        i_pt.ready  = 1'b0;

        unique case (r_state)
            qpi_pkg::ST_CLEAR: begin
                // One slot per cycle is zeroed after reset.
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == SLOT_BITS'(NODE_SLOTS - 1)) begin
                    n_state = qpi_pkg::ST_IDLE;
                end
            end

            qpi_pkg::ST_IDLE: begin
                // Take a request and start reading the root link word at
                // once; an outside point simply ignores that read.
                i_pt.ready = 1'b1;
                ram_raddr  = SLOT_BITS'(qpi_pkg::ROOT_SLOT);
                if (i_pt.valid) begin
                    ram_re   = 1'b1;
                    n_px     = i_pt.payload.point_x;
                    n_py     = i_pt.payload.point_y;
                    n_left   = '0;
                    n_top    = '0;
                    n_w      = r_grid_width;
                    n_h      = r_grid_height;
                    n_node   = SLOT_BITS'(qpi_pkg::ROOT_SLOT);
                    n_lvl    = '0;
                    n_reject = (i_pt.payload.point_x >= r_grid_width) ||
                               (i_pt.payload.point_y >= r_grid_height);
                    n_state  = qpi_pkg::ST_WALK;
                end
            end

            qpi_pkg::ST_WALK: begin
                // One level per cycle. Each cycle reports the current node
                // and, when the walk goes on, links or allocates its group
                // and reads the chosen child's link word. A held output
                // register freezes everything, including the RAM read data.
                if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_out.node_index     = qpi_pkg::NODE_BITS'(r_node);
                    n_out.level          = qpi_pkg::LEVEL_BITS'(r_lvl);
                    n_out.rejected       = 1'b0;
                    n_out.store_full     = 1'b0;
                    n_out.last           = 1'b0;
                    if (r_reject) begin
                        n_out.node_index = '0;
                        n_out.level      = '0;
                        n_out.rejected   = 1'b1;
                        n_out.last       = 1'b1;
                        n_state          = qpi_pkg::ST_IDLE;
                    end else if (stop_geo) begin
                        n_out.last       = 1'b1;
                        n_state          = qpi_pkg::ST_IDLE;
                    end else if (is_leaf && full) begin
                        // No group of four is left: the node stays a leaf.
                        n_out.store_full = 1'b1;
                        n_out.last       = 1'b1;
                        n_state          = qpi_pkg::ST_IDLE;
                    end else begin
                        if (is_leaf) begin
                            ram_we      = 1'b1;
                            n_next_free = r_next_free + (SLOT_BITS + 1)'(qpi_pkg::GROUP_SIZE);
                        end
                        // The child slot is always newer than its parent, so
                        // this read never meets the write of the same cycle.
                        ram_re = 1'b1;
                        // West and north halves get floor(len/2); east and
                        // south halves get the rest.
                        if (quad[qpi_pkg::QUAD_EAST]) begin
                            n_left = cx;
                            n_w    = r_w - (r_w >> 1);
                        end else begin
                            n_w    = r_w >> 1;
                        end
                        if (quad[qpi_pkg::QUAD_SOUTH]) begin
                            n_top = cy;
                            n_h   = r_h - (r_h >> 1);
                        end else begin
                            n_h   = r_h >> 1;
                        end
                        n_node = child;
                        n_lvl  = r_lvl + 1'b1;
                    end
                end
            end

            default: begin
                n_state = qpi_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

`ifndef SYNTHESIS
    // The bump pointer never runs past the store.
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_free <= (SLOT_BITS + 1)'(NODE_SLOTS))
        else $error("next free slot beyond the store");

    // An allocation only ever overwrites a leaf entry.
    a_alloc_leaf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && r_state == qpi_pkg::ST_WALK) |-> (ram_rdata == '0))
        else $error("child link overwritten");

    // An accepted request starts a walk on the next cycle.
    a_accept_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pt.valid && i_pt.ready) |=> (r_state == qpi_pkg::ST_WALK))
        else $error("request accepted without starting a walk");

    // Rejected and store-full results always close the insertion.
    a_flag_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.payload.rejected || o_res.payload.store_full))
        |-> o_res.payload.last)
        else $error("flagged result not marked last");

    // Each walk allocates at most one group per cycle.
    a_alloc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == qpi_pkg::ST_WALK && $past(r_state) == qpi_pkg::ST_WALK) |->
        ((r_next_free == $past(r_next_free)) ||
         (r_next_free == $past(r_next_free) + (SLOT_BITS + 1)'(qpi_pkg::GROUP_SIZE))))
        else $error("bump pointer moved by more than one group");
`endif
endmodule
